[hw/rtl/gmes_pkg.sv]
package gmes_pkg;

  localparam int unsigned ColW    = 7;
  localparam int unsigned PosW    = 6;
  localparam int unsigned TotalW  = 25;
  localparam int unsigned PixW    = 24;
  localparam int unsigned EnergyW = 20;

  typedef enum logic [1:0] {
    RegWidth     = 2'd0,
    RegHeight    = 2'd1,
    RegDirection = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic          start;
    logic [PosW:0] w;
    logic [PosW:0] h;
    logic          horiz;
  } search_cmd_t;

  typedef struct packed {
    logic [PosW-1:0]   index;
    logic [PosW-1:0]   position;
    logic [TotalW-1:0] total;
    logic              last;
  } seam_entry_t;

  function automatic logic [16:0] sq_diff8(logic [7:0] a, logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 17'(d * d);
  endfunction

  function automatic logic [18:0] rgb_dist(logic [PixW-1:0] p, logic [PixW-1:0] q);
    return 19'(sq_diff8(p[23:16], q[23:16])) + 19'(sq_diff8(p[15:8], q[15:8]))
         + 19'(sq_diff8(p[7:0], q[7:0]));
  endfunction

endpackage

[hw/rtl/gmes_energy.sv]
module gmes_energy (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gmes_pkg::PosW-1:0]     x_i,
  input  logic [gmes_pkg::PosW-1:0]     y_i,
  input  logic [gmes_pkg::PosW:0]       w_i,
  input  logic [gmes_pkg::PosW:0]       h_i,
  output logic                          rd_en_o,
  output logic [2*gmes_pkg::PosW-1:0]   rd_addr_o,
  input  logic [gmes_pkg::PixW-1:0]     rd_data_i,
  output logic                          done_o,
  output logic [gmes_pkg::EnergyW-1:0]  energy_o
);

  logic [2:0] cnt_q, cnt_d;
  logic       busy_q, busy_d;
  logic [gmes_pkg::PixW-1:0]    held_q, held_d;
  logic [gmes_pkg::EnergyW-1:0] acc_q, acc_d;
  logic [gmes_pkg::EnergyW-1:0] sum;
  logic [gmes_pkg::PosW-1:0] xl, xr, yd, yu, ax, ay;
  logic [gmes_pkg::PosW-1:0] wm1, hm1;

  assign wm1 = gmes_pkg::PosW'(w_i - 7'd1);
  assign hm1 = gmes_pkg::PosW'(h_i - 7'd1);
  assign xl  = (x_i == '0) ? wm1 : x_i - 6'd1;
  assign xr  = (x_i >= wm1) ? '0 : x_i + 6'd1;
  assign yd  = (y_i == '0) ? hm1 : y_i - 6'd1;
  assign yu  = (y_i >= hm1) ? '0 : y_i + 6'd1;

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    begin ax = xl;  ay = y_i; end
      2'd1:    begin ax = xr;  ay = y_i; end
      2'd2:    begin ax = x_i; ay = yd;  end
      default: begin ax = x_i; ay = yu;  end
    endcase
  end

  assign rd_en_o   = busy_q && (cnt_q < 3'd4);
  assign rd_addr_o = {ay, ax};

  assign sum      = acc_q + gmes_pkg::EnergyW'(gmes_pkg::rgb_dist(held_q, rd_data_i));
  assign done_o   = busy_q && (cnt_q == 3'd4);
  assign energy_o = sum;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    held_d = held_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd1 || cnt_q == 3'd3) begin
        held_d = rd_data_i;
      end
      if (cnt_q == 3'd2 || cnt_q == 3'd4) begin
        acc_d = sum;
      end
      if (cnt_q == 3'd4) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

[hw/rtl/gmes_search.sv]
module gmes_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gmes_pkg::search_cmd_t         cmd_i,
  output logic                          busy_o,
  output logic                          rd_en_o,
  output logic [2*gmes_pkg::PosW-1:0]   rd_addr_o,
  input  logic [gmes_pkg::PixW-1:0]     rd_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gmes_pkg::seam_entry_t         out_o
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StStart = 7'b0000010,
    StMid   = 7'b0000100,
    StPlus  = 7'b0001000,
    StMinus = 7'b0010000,
    StPick  = 7'b0100000,
    StEmit  = 7'b1000000
  } state_e;

  localparam int unsigned PosW = gmes_pkg::PosW;
  localparam int unsigned TotW = gmes_pkg::TotalW;
  localparam int unsigned EW   = gmes_pkg::EnergyW;

  state_e st_q, st_d;
  logic [PosW:0] w_q, h_q;
  logic          horiz_q;
  logic [PosW-1:0] s_q, s_d, i_q, i_d, p_q, p_d;
  logic [TotW-1:0] trial_q, trial_d, best_q, best_d;
  logic [EW-1:0] mid_q, mid_d, plus_q, plus_d;
  logic [PosW:0] len, span;
  logic          e_start, e_done;
  logic [PosW-1:0] e_pos;
  logic [EW-1:0] e_val;
  logic          tr_we;
  logic [PosW-1:0] tr_waddr, tr_val, bs_raddr;
  logic [PosW-1:0] best_rd_q;
  logic          emit_pend_q, emit_pend_d;
  logic [PosW-1:0] best_mem0 [2**PosW];
  logic [PosW-1:0] best_mem1 [2**PosW];
  logic          bank_q, bank_d;

  assign len  = horiz_q ? w_q : h_q;
  assign span = horiz_q ? h_q : w_q;
  assign busy_o = (st_q != StIdle);

  // Two banks of seam positions: the trial walk writes the spare bank, and a
  // better total flips which bank holds the winner.

  gmes_energy u_energy (
    .clk_i,
    .rst_ni,
    .start_i   (e_start),
    .x_i       (horiz_q ? i_q : e_pos),
    .y_i       (horiz_q ? e_pos : i_q),
    .w_i       (w_q),
    .h_i       (h_q),
    .rd_en_o,
    .rd_addr_o,
    .rd_data_i,
    .done_o    (e_done),
    .energy_o  (e_val)
  );

  always_comb begin
    st_d = st_q; s_d = s_q; i_d = i_q; p_d = p_q;
    trial_d = trial_q; best_d = best_q; mid_d = mid_q; plus_d = plus_q;
    e_start = 1'b0; e_pos = p_q;
    tr_we = 1'b0; tr_waddr = i_q; tr_val = p_q;
    bank_d = bank_q;
    emit_pend_d = emit_pend_q;
    out_valid_o = 1'b0;
    bs_raddr = i_q;
    unique case (st_q)
      StIdle: begin
        if (cmd_i.start) begin
          st_d = StStart; s_d = '0; i_d = '0; p_d = '0; e_start = 1'b1; e_pos = '0;
        end
      end
      StStart: begin
        if (e_done) begin
          trial_d = TotW'(e_val); tr_we = 1'b1; tr_waddr = '0; tr_val = p_q;
          if (len == 7'd1) begin
            st_d = StPick;
          end else begin
            i_d = 6'd1; st_d = StMid; e_start = 1'b1; e_pos = p_q;
          end
        end
      end
      StMid: begin
        e_pos = p_q;
        if (e_done) begin
          mid_d = e_val;
          if ({1'b0, p_q} + 7'd1 < span) begin
            st_d = StPlus; e_start = 1'b1; e_pos = p_q + 6'd1;
          end else if (p_q != '0) begin
            plus_d = e_val; st_d = StMinus; e_start = 1'b1; e_pos = p_q - 6'd1;
          end else begin
            trial_d = trial_q + TotW'(e_val);
            tr_we = 1'b1; tr_val = p_q;
            st_d = StPick;
          end
        end
      end
      StPlus: begin
        e_pos = p_q + 6'd1;
        if (e_done) begin
          plus_d = e_val;
          if (p_q != '0) begin
            st_d = StMinus; e_start = 1'b1; e_pos = p_q - 6'd1;
          end else begin
            st_d = StPick;
            if (e_val < mid_q) begin
              p_d = p_q + 6'd1; trial_d = trial_q + TotW'(e_val); tr_val = p_q + 6'd1;
            end else begin
              trial_d = trial_q + TotW'(mid_q);
            end
            tr_we = 1'b1;
          end
        end
      end
      StMinus: begin
        e_pos = p_q - 6'd1;
        if (e_done) begin
          st_d = StPick; tr_we = 1'b1;
          priority if (e_val < mid_q && e_val < plus_q) begin
            p_d = p_q - 6'd1; trial_d = trial_q + TotW'(e_val); tr_val = p_q - 6'd1;
          end else if (plus_q < mid_q) begin
            p_d = p_q + 6'd1; trial_d = trial_q + TotW'(plus_q); tr_val = p_q + 6'd1;
          end else begin
            trial_d = trial_q + TotW'(mid_q);
          end
        end
      end
      StPick: begin
        if ({1'b0, i_q} + 7'd1 < len && !(len == 7'd1)) begin
          i_d = i_q + 6'd1; st_d = StMid; e_start = 1'b1; e_pos = p_q;
        end else begin
          if (s_q == '0 || trial_q < best_q) begin
            best_d = trial_q; bank_d = ~bank_q;
          end
          if ({1'b0, s_q} + 7'd1 < span) begin
            s_d = s_q + 6'd1; p_d = s_q + 6'd1; i_d = '0;
            st_d = StStart; e_start = 1'b1; e_pos = s_q + 6'd1;
          end else begin
            i_d = '0; st_d = StEmit; emit_pend_d = 1'b0;
          end
        end
      end
      StEmit: begin
        bs_raddr = emit_pend_q && out_ready_i ? i_q + 6'd1 : i_q;
        out_valid_o = emit_pend_q;
        if (!emit_pend_q) begin
          emit_pend_d = 1'b1;
        end else if (out_ready_i) begin
          if ({1'b0, i_q} + 7'd1 >= len) begin
            st_d = StIdle; emit_pend_d = 1'b0;
          end else begin
            i_d = i_q + 6'd1;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  assign out_o.index    = i_q;
  assign out_o.position = best_rd_q;
  assign out_o.total    = best_q;
  assign out_o.last     = ({1'b0, i_q} + 7'd1 == len);

  always_ff @(posedge clk_i) begin
    if (tr_we) begin
      if (bank_q) best_mem0[tr_waddr] <= tr_val;
      else        best_mem1[tr_waddr] <= tr_val;
    end
    best_rd_q <= bank_q ? best_mem1[bs_raddr] : best_mem0[bs_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; s_q <= '0; i_q <= '0; p_q <= '0;
      trial_q <= '0; best_q <= '0; mid_q <= '0; plus_q <= '0;
      bank_q <= 1'b0; emit_pend_q <= 1'b0;
      w_q <= 7'd64; h_q <= 7'd64; horiz_q <= 1'b0;
    end else begin
      st_q <= st_d; s_q <= s_d; i_q <= i_d; p_q <= p_d;
      trial_q <= trial_d; best_q <= best_d; mid_q <= mid_d; plus_q <= plus_d;
      bank_q <= bank_d;
      emit_pend_q <= emit_pend_d;
      if (cmd_i.start && st_q == StIdle) begin
        w_q <= cmd_i.w; h_q <= cmd_i.h; horiz_q <= cmd_i.horiz;
      end
    end
  end

endmodule

[hw/rtl/greedy_min_energy_seam_finder_top.sv]
// Channel  | Dir | Handshake              | Payload
// s_axis   | in  | s_axis_tvalid/tready   | tdata: red[7:0], green[15:8], blue[23:16]
// m_axis   | out | m_axis_tvalid/tready   | tdata: index, position, total; tlast
// cfg      | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
// Pixels load at one per cycle while no search runs, into a store with one
// write port and one read port. The last pixel starts a search; each energy
// reads its four neighbours through the shared read port, and a step takes up
// to three energies (middle, plus, minus) and then picks the move.
// No pixel is taken during the search or while the seam is sent out.
// Reset is asynchronous and active low; sizes reset to 64 by 64, vertical.
module greedy_min_energy_seam_finder_top #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red, green, blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // seam_index, seam_position, seam_total_energy
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  localparam int unsigned PosW = gmes_pkg::PosW;

  logic [6:0] wr_q, hr_q;
  logic       dir_q;
  logic [6:0] w_eff, h_eff, col_q, row_q;
  logic       busy, load_acc, done_pix;
  gmes_pkg::search_cmd_t cmd;
  gmes_pkg::seam_entry_t ent;
  logic       rd_en;
  logic [2*PosW-1:0] rd_addr;
  logic [23:0] rd_data_q;
  logic [23:0] store [2**(2*PosW)];

  function automatic logic [6:0] clampv(logic [6:0] v, int unsigned m);
    if (v < 7'd2) return 7'd2;
    if (v > 7'(m)) return 7'(m);
    return v;
  endfunction

  assign w_eff = clampv(wr_q, MAX_WIDTH);
  assign h_eff = clampv(hr_q, MAX_HEIGHT);
  assign s_axis_tready = !busy;
  assign cfg_ready_o   = 1'b1;
  assign load_acc = s_axis_tvalid && s_axis_tready;
  assign done_pix = (col_q + 7'd1 >= w_eff) && (row_q + 7'd1 >= h_eff);

  assign cmd.start = load_acc && done_pix;
  assign cmd.w     = w_eff;
  assign cmd.h     = h_eff;
  assign cmd.horiz = dir_q;

  gmes_search u_search (
    .clk_i, .rst_ni,
    .cmd_i (cmd), .busy_o (busy),
    .rd_en_o (rd_en), .rd_addr_o (rd_addr), .rd_data_i (rd_data_q),
    .out_valid_o (m_axis_tvalid), .out_ready_i (m_axis_tready), .out_o (ent)
  );

  assign m_axis_tdata = {3'b0, ent.total, ent.position, ent.index};
  assign m_axis_tlast = ent.last;

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      store[{row_q[PosW-1:0], col_q[PosW-1:0]}] <=
        {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
    end
    if (rd_en) rd_data_q <= store[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 7'd64; hr_q <= 7'd64; dir_q <= 1'b0; col_q <= '0; row_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          gmes_pkg::RegWidth:     begin wr_q <= cfg_data_i; col_q <= '0; row_q <= '0; end
          gmes_pkg::RegHeight:    begin hr_q <= cfg_data_i; col_q <= '0; row_q <= '0; end
          gmes_pkg::RegDirection: dir_q <= cfg_data_i[0];
          default: ;
        endcase
      end else if (load_acc) begin
        if (done_pix) begin
          col_q <= '0; row_q <= '0;
        end else if (col_q + 7'd1 >= w_eff) begin
          col_q <= '0; row_q <= row_q + 7'd1;
        end else begin
          col_q <= col_q + 7'd1;
        end
      end
    end
  end

endmodule
